// ===== hw/rtl/carp_pkg.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// carp_pkg
// Shared types, fixed-point constants and the cosine lookup for the cascaded
// angle/rate PID block.
// -----------------------------------------------------------------------------
package carp_pkg;

   // Q format and loop constants
   localparam int     FracBits    = 16;
   localparam longint PiQ30       = 64'sd3373259426;
   localparam longint OneQ        = 64'sd1 <<< FracBits;
   localparam longint PiQ         = (PiQ30 + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
   localparam longint TwoPiQ      = (PiQ30 + (64'sd1 <<< (28 - FracBits))) >>> (29 - FracBits);
   localparam longint DeadbandQ   = (OneQ + 50) / 100;
   localparam longint RateLimitQ  = 15 * OneQ;
   localparam longint UpperPosQ   = (4 * OneQ + 2) / 5;
   localparam longint LowerPosQ   = (OneQ + 2) / 5;
   localparam logic [31:0] DtQ32  = 32'd4294967;
   localparam int     InvDt       = 1000;

   // datapath widths
   localparam int ErrW   = 32;
   localparam int IntegW = 48;
   localparam int AccW   = 64;
   localparam int ProdW  = 96;
   localparam int DiffW  = 44;
   localparam int OutW   = 21;

   // cosine lookup: index = floor((angle*2*Depth + 2pi) / (2*2pi)) mod Depth
   localparam int     CosDepth     = 256;
   localparam int     CosDepthBits = 8;
   localparam int     CosQuarter   = CosDepth / 4;
   localparam int     CosW         = FracBits + 2;
   localparam longint CosStep      = 2 * TwoPiQ;
   localparam longint CosBias      = 164;
   localparam int     CosMW        = 29;
   localparam int     CosQW        = 10;
   localparam int     CosRecipSh   = 48;
   localparam longint CosRecip     = (64'sd1 <<< CosRecipSh) / CosStep;
   localparam longint CosOffset    = TwoPiQ + CosBias * CosStep;

   typedef logic signed [CosW-1:0] cos_table_type [CosDepth];

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ERR_A,
      ST_INT_A,
      ST_LOAD,
      ST_LO,
      ST_HI,
      ST_FIN,
      ST_OUT_A,
      ST_ERR_R,
      ST_INT_R,
      ST_OUT_R
   } state_type;

   // multiply kinds within one PID evaluation, in issue order
   typedef enum logic [1:0] {
      OP_PROP,
      OP_INTEG,
      OP_SCALE,
      OP_DERIV
   } op_type;

   typedef enum logic [2:0] {
      CSR_ANGLE_PROP,
      CSR_ANGLE_INTEG,
      CSR_ANGLE_DERIV,
      CSR_RATE_PROP,
      CSR_RATE_INTEG,
      CSR_RATE_DERIV
   } csr_index_type;

   typedef struct packed {
      logic   capture;
      logic   err_angle;
      logic   integ_angle;
      logic   err_rate;
      logic   integ_rate;
      logic   mul_load;
      logic   mul_lo;
      logic   mul_hi;
      logic   mul_fin;
      logic   out_angle;
      logic   out_rate;
      logic   inner_loop;
      op_type op;
   } cmd_type;

   // Q30 Taylor cosine on the quarter turn, rounded into Q format
   function automatic cos_table_type build_cos_table();
      cos_table_type tbl;
      longint        r;
      longint        x;
      longint        x2;
      longint        t;
      longint        c;
      longint        one;
      int            quad;
      one = 64'sd1 <<< 30;
      for (int k = 0; k < CosDepth; k++) begin
         quad = k >> (CosDepthBits - 2);
         r = longint'(k & (CosQuarter - 1)) <<< (30 - CosDepthBits + 2);
         if (quad % 2 == 1) begin
            r = one - r;
         end
         x  = (r * PiQ30) >>> 31;
         x2 = (x * x) >>> 30;
         t  = one;
         t  = one - ((x2 * t) >>> 30) / 132;
         if (t < 0) t = 0;
         t  = one - ((x2 * t) >>> 30) / 90;
         if (t < 0) t = 0;
         t  = one - ((x2 * t) >>> 30) / 56;
         if (t < 0) t = 0;
         t  = one - ((x2 * t) >>> 30) / 30;
         if (t < 0) t = 0;
         t  = one - ((x2 * t) >>> 30) / 12;
         if (t < 0) t = 0;
         t  = one - ((x2 * t) >>> 30) / 2;
         if (t < 0) t = 0;
         c = (t + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
         tbl[k] = (quad == 1 || quad == 2) ? CosW'(-c) : CosW'(c);
      end
      return tbl;
   endfunction

endpackage

// ===== hw/rtl/carp_ctrl.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// carp_ctrl
// Sequencer: steps both PID loops through the shared multiplier and owns the
// request and response handshakes.
// -----------------------------------------------------------------------------
module carp_ctrl
   import carp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   state_type  state_ff, state_in;
   logic [2:0] op_ff, op_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_ERR_A;
         ST_ERR_A: state_in = ST_INT_A;
         ST_INT_A: state_in = ST_LOAD;
         ST_LOAD:  state_in = ST_LO;
         ST_LO:    state_in = ST_HI;
         ST_HI:    state_in = ST_FIN;
         ST_FIN: begin
            if (op_type'(op_ff[1:0]) == OP_DERIV) begin
               state_in = op_ff[2] ? ST_OUT_R : ST_OUT_A;
            end else begin
               state_in = ST_LOAD;
            end
         end
         ST_OUT_A: state_in = ST_ERR_R;
         ST_ERR_R: state_in = ST_INT_R;
         ST_INT_R: state_in = ST_LOAD;
         ST_OUT_R: if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd             = '0;
      cmd.inner_loop  = op_ff[2];
      cmd.op          = op_type'(op_ff[1:0]);
      req_ready       = 1'b0;
      op_in           = op_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            op_in       = '0;
         end
         ST_ERR_A: cmd.err_angle   = 1'b1;
         ST_INT_A: cmd.integ_angle = 1'b1;
         ST_LOAD:  cmd.mul_load    = 1'b1;
         ST_LO:    cmd.mul_lo      = 1'b1;
         ST_HI:    cmd.mul_hi      = 1'b1;
         ST_FIN: begin
            cmd.mul_fin = 1'b1;
            op_in       = op_ff + 3'd1;
         end
         ST_OUT_A: cmd.out_angle   = 1'b1;
         ST_ERR_R: cmd.err_rate    = 1'b1;
         ST_INT_R: cmd.integ_rate  = 1'b1;
         ST_OUT_R: cmd.out_rate    = slot_free;
         default:  cmd             = '0;
      endcase
   end

   assign rsp_valid_in = cmd.out_rate || (rsp_valid_ff && !rsp_ready);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         op_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== hw/rtl/carp_dpath.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// carp_dpath
// Datapath: gain registers, loop state, one 32x32 multiplier and the cosine
// lookup pipeline.
// -----------------------------------------------------------------------------
module carp_dpath
   import carp_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_en,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_write_data,
   input  logic signed [18:0]     req_measured_angle,
   input  logic signed [22:0]     req_measured_rate,
   input  logic signed [18:0]     req_filtered_position,
   input  logic signed [18:0]     req_target_angle,
   input  logic signed [22:0]     req_target_rate,
   input  logic                   req_opcode,
   input  cmd_type                cmd,
   output logic signed [OutW-1:0] rsp_drive_command,
   output logic signed [OutW-1:0] rsp_rate_loop_output,
   output logic signed [31:0]     rsp_angle_loop_output,
   output logic                   rsp_limit_gated
);

   localparam cos_table_type CosTable = build_cos_table();

   localparam logic signed [20:0]     PiW     = 21'(PiQ);
   localparam logic signed [20:0]     TwoPiW  = 21'(TwoPiQ);
   localparam logic signed [ErrW-1:0] DbW     = ErrW'(DeadbandQ);
   localparam logic signed [AccW-1:0] RateMax = AccW'(RateLimitQ);
   localparam logic signed [18:0]     UpperW  = 19'(UpperPosQ);
   localparam logic signed [18:0]     LowerW  = 19'(LowerPosQ);
   localparam logic signed [AccW-1:0] I32Max  = AccW'(32'sh7fffffff);
   localparam logic signed [AccW-1:0] I32Min  = -AccW'(64'sh80000000);
   localparam logic signed [21:0]     O21Max  = 22'((64'sd1 <<< (OutW - 1)) - 1);
   localparam logic signed [21:0]     O21Min  = -22'(64'sd1 <<< (OutW - 1));
   localparam logic [CosMW-1:0]       RecipW  = CosMW'(CosRecip);
   localparam logic [CosMW:0]         StepW   = (CosMW + 1)'(CosStep);

   function automatic logic signed [ErrW-1:0] deadband(input logic signed [ErrW-1:0] e);
      return (e < DbW && e > -DbW) ? '0 : e;
   endfunction

   // captured request
   logic signed [18:0] angle_ff, pos_ff, tgt_angle_ff;
   logic signed [22:0] rate_ff, tgt_rate_ff;
   logic               mode_ff;

   logic [31:0] gain_ff [6];

   // loop state
   logic signed [ErrW-1:0]   ea_ff, er_ff, prev_a_ff, prev_r_ff;
   logic signed [IntegW-1:0] ai_ff, ri_ff;
   logic signed [DiffW-1:0]  dd_ff;
   logic signed [AccW-1:0]   pid_ff, tmp_ff, outer_ff;

   // multiplier
   logic [AccW-1:0]  mag_ff;
   logic             neg_ff;
   logic [31:0]      b_ff;
   logic [ProdW-1:0] acc_ff;

   // cosine index pipeline
   logic [CosMW-1:0] cm_ff, cm2_ff;
   logic [CosQW-1:0] cq_ff, cq2_ff;
   logic [CosMW:0]   cback_ff;

   // response words
   logic signed [OutW-1:0] drive_ff, inner_ff;
   logic signed [31:0]     angle_out_ff;
   logic                   gated_ff;

   // angle error: wrap once into +-pi, then deadband
   logic signed [19:0] ea_raw;
   logic signed [20:0] ea_wide;
   always_comb begin
      ea_raw  = 20'(tgt_angle_ff) - 20'(angle_ff);
      ea_wide = 21'(ea_raw);
      if (ea_wide > PiW) begin
         ea_wide = ea_wide - TwoPiW;
      end else if (ea_wide < -PiW) begin
         ea_wide = ea_wide + TwoPiW;
      end
   end

   // rate error: saturate to 32 bits, then deadband
   logic signed [32:0]     er_raw;
   logic signed [ErrW-1:0] er_sat;
   always_comb begin
      er_raw = (mode_ff ? 33'(tgt_rate_ff) : 33'($signed(outer_ff[31:0]))) - 33'(rate_ff);
      if (er_raw[32] != er_raw[31]) begin
         er_sat = er_raw[32] ? {1'b1, {(ErrW-1){1'b0}}} : {1'b0, {(ErrW-1){1'b1}}};
      end else begin
         er_sat = er_raw[31:0];
      end
   end

   // integral update and error difference for the loop in hand
   logic signed [ErrW-1:0]   e_sel, prev_sel;
   logic signed [IntegW-1:0] integ_sel, integ_next;
   logic signed [IntegW:0]   integ_sum;
   logic signed [32:0]       e_diff;
   logic signed [DiffW-1:0]  dd_next;
   always_comb begin
      e_sel     = cmd.inner_loop ? er_ff : ea_ff;
      prev_sel  = cmd.inner_loop ? prev_r_ff : prev_a_ff;
      integ_sel = cmd.inner_loop ? ri_ff : ai_ff;
      integ_sum = (IntegW+1)'(integ_sel) + (IntegW+1)'(e_sel);
      if (integ_sum[IntegW] != integ_sum[IntegW-1]) begin
         integ_next = integ_sum[IntegW] ? {1'b1, {(IntegW-1){1'b0}}}
                                        : {1'b0, {(IntegW-1){1'b1}}};
      end else begin
         integ_next = integ_sum[IntegW-1:0];
      end
      e_diff  = 33'(e_sel) - 33'(prev_sel);
      dd_next = DiffW'(e_diff) * DiffW'(InvDt);
   end

   // multiplier operand and coefficient
   logic signed [AccW-1:0] opnd;
   logic [31:0]            coef;
   logic [2:0]             gidx;
   always_comb begin
      gidx = 3'(CSR_ANGLE_PROP);
      case (cmd.op)
         OP_PROP:  opnd = AccW'(e_sel);
         OP_INTEG: opnd = AccW'(integ_sel);
         OP_SCALE: opnd = tmp_ff;
         OP_DERIV: opnd = AccW'(dd_ff);
         default:  opnd = '0;
      endcase
      case (cmd.op)
         OP_PROP:  gidx = cmd.inner_loop ? 3'(CSR_RATE_PROP)  : 3'(CSR_ANGLE_PROP);
         OP_INTEG: gidx = cmd.inner_loop ? 3'(CSR_RATE_INTEG) : 3'(CSR_ANGLE_INTEG);
         OP_DERIV: gidx = cmd.inner_loop ? 3'(CSR_RATE_DERIV) : 3'(CSR_ANGLE_DERIV);
         default:  gidx = 3'(CSR_ANGLE_PROP);
      endcase
      coef = (cmd.op == OP_SCALE) ? DtQ32 : gain_ff[gidx];
   end

   // one 32x32 multiplier, low half then high half of the magnitude
   logic [31:0] mul_a;
   logic [63:0] mul_p;
   assign mul_a = cmd.mul_hi ? mag_ff[63:32] : mag_ff[31:0];
   assign mul_p = mul_a * b_ff;

   // shift, saturate to 64 bits, restore sign, saturating accumulate
   logic [ProdW-1:0]       shifted;
   logic [AccW-1:0]        limit, sat_mag;
   logic signed [AccW-1:0] res, pid_next;
   logic signed [AccW:0]   pid_sum;
   always_comb begin
      shifted = (cmd.op == OP_SCALE) ? (acc_ff >> 32) : (acc_ff >> FracBits);
      limit   = neg_ff ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      sat_mag = (shifted > ProdW'(limit)) ? limit : shifted[AccW-1:0];
      res     = neg_ff ? -$signed(sat_mag) : $signed(sat_mag);
      pid_sum = (AccW+1)'(pid_ff) + (AccW+1)'(res);
      if (pid_sum[AccW] != pid_sum[AccW-1]) begin
         pid_next = pid_sum[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
      end else begin
         pid_next = pid_sum[AccW-1:0];
      end
   end

   // inner output: clamp, position gating, gravity term
   logic signed [AccW-1:0] inner_c;
   logic signed [OutW-1:0] inner_g;
   logic                   gated;
   logic signed [21:0]     drive_sum;
   logic signed [OutW-1:0] drive_sat;
   logic signed [AccW-1:0] outer_sat;
   logic [CosMW:0]         cos_rem;
   logic [CosQW-1:0]       cos_q;
   logic [CosDepthBits-1:0] cos_idx;
   logic signed [CosW-1:0] cos_val;
   always_comb begin
      inner_c = pid_ff;
      if (pid_ff > RateMax) begin
         inner_c = RateMax;
      end else if (pid_ff < -RateMax) begin
         inner_c = -RateMax;
      end
      gated   = (pos_ff > UpperW && inner_c > 0) || (pos_ff < -LowerW && inner_c < 0);
      inner_g = gated ? '0 : OutW'(inner_c);

      cos_rem = (CosMW+1)'(cm2_ff) - cback_ff;
      cos_q   = cq2_ff + ((cos_rem >= StepW) ? CosQW'(1) : CosQW'(0));
      cos_idx = CosDepthBits'(cos_q - CosQW'(CosBias));
      cos_val = CosTable[cos_idx];

      drive_sum = 22'(inner_g) + 22'(cos_val);
      if (drive_sum > O21Max) begin
         drive_sat = OutW'(O21Max);
      end else if (drive_sum < O21Min) begin
         drive_sat = OutW'(O21Min);
      end else begin
         drive_sat = OutW'(drive_sum);
      end

      outer_sat = pid_ff;
      if (pid_ff > I32Max) begin
         outer_sat = I32Max;
      end else if (pid_ff < I32Min) begin
         outer_sat = I32Min;
      end
   end

   // cosine index: biased offset, reciprocal estimate, one correction
   logic signed [CosMW:0] cm_signed;
   logic [2*CosMW-1:0]    cq_prod;
   assign cm_signed = ((CosMW+1)'(angle_ff) <<< (CosDepthBits + 1)) + (CosMW+1)'(CosOffset);
   assign cq_prod   = cm_signed[CosMW-1:0] * RecipW;

   always_ff @(posedge clock) begin
      cm_ff    <= cm_signed[CosMW-1:0];
      cq_ff    <= CosQW'(cq_prod >> CosRecipSh);
      cm2_ff   <= cm_ff;
      cq2_ff   <= cq_ff;
      cback_ff <= (CosMW+1)'(cq_ff) * StepW;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            gain_ff[i] <= '0;
         end
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ANGLE_PROP,
            CSR_ANGLE_INTEG,
            CSR_ANGLE_DERIV,
            CSR_RATE_PROP,
            CSR_RATE_INTEG,
            CSR_RATE_DERIV: gain_ff[csr_index] <= csr_write_data;
            default: ;
         endcase
      end
   end

   // loop state
   always_ff @(posedge clock) begin
      if (reset) begin
         ai_ff     <= '0;
         ri_ff     <= '0;
         prev_a_ff <= '0;
         prev_r_ff <= '0;
      end else begin
         if (cmd.integ_angle) begin
            ai_ff     <= integ_next;
            prev_a_ff <= ea_ff;
         end
         if (cmd.integ_rate) begin
            ri_ff     <= integ_next;
            prev_r_ff <= er_ff;
         end
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         angle_ff     <= req_measured_angle;
         rate_ff      <= req_measured_rate;
         pos_ff       <= req_filtered_position;
         tgt_angle_ff <= req_target_angle;
         tgt_rate_ff  <= req_target_rate;
         mode_ff      <= req_opcode;
      end
      if (cmd.err_angle) ea_ff <= deadband(ErrW'(ea_wide));
      if (cmd.err_rate)  er_ff <= deadband(er_sat);
      if (cmd.integ_angle || cmd.integ_rate) begin
         dd_ff  <= dd_next;
         pid_ff <= '0;
      end
      if (cmd.mul_load) begin
         mag_ff <= opnd[AccW-1] ? AccW'(-opnd) : AccW'(opnd);
         neg_ff <= opnd[AccW-1];
         b_ff   <= coef;
      end
      if (cmd.mul_lo) acc_ff <= ProdW'(mul_p);
      if (cmd.mul_hi) acc_ff <= acc_ff + {mul_p, 32'b0};
      if (cmd.mul_fin) begin
         if (cmd.op == OP_INTEG) begin
            tmp_ff <= res;
         end else begin
            pid_ff <= pid_next;
         end
      end
      if (cmd.out_angle) outer_ff <= outer_sat;
      if (cmd.out_rate) begin
         drive_ff     <= drive_sat;
         inner_ff     <= inner_g;
         angle_out_ff <= outer_ff[31:0];
         gated_ff     <= gated;
      end
   end

   assign rsp_drive_command     = drive_ff;
   assign rsp_rate_loop_output  = inner_ff;
   assign rsp_angle_loop_output = angle_out_ff;
   assign rsp_limit_gated       = gated_ff;

endmodule

// ===== hw/rtl/cascaded_angle_rate_pid_top.sv =====
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// cascaded_angle_rate_pid_top
// Cascaded angle/rate PID for a pitch joint with cosine gravity feed-forward.
//
//   channel   direction  handshake              carries
//   req_*     in         req_valid/req_ready    one sensor and target word
//   rsp_*     out        rsp_valid/rsp_ready    drive, loop outputs, gate flag
//   csr_*     in         csr_write_en           gain writes, index 0..5
//
// Each PID loop runs four products (P, integral, dt scale, D) through the
// single 32x32 multiplier, each in load, low-half, high-half and finish
// steps, plus error, integral and output steps. One word is in flight at a
// time; req_ready is high only in idle.
// The response sits in an output register, so a new word is taken while the
// previous response still waits; the block holds in its last step if that
// register is still full. Reset is synchronous and clears gains and loop state.
// -----------------------------------------------------------------------------
module cascaded_angle_rate_pid_top
   import carp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [18:0] req_measured_angle,
   input  logic signed [22:0] req_measured_rate,
   input  logic signed [18:0] req_filtered_position,
   input  logic signed [18:0] req_target_angle,
   input  logic signed [22:0] req_target_rate,
   input  logic               req_opcode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [20:0] rsp_drive_command,
   output logic signed [20:0] rsp_rate_loop_output,
   output logic signed [31:0] rsp_angle_loop_output,
   output logic               rsp_limit_gated
);

   cmd_type cmd;

   // sequencer: steps the loops and owns both handshakes
   carp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   // arithmetic, loop state, gains and response word
   carp_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .csr_write_en          (csr_write_en),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data),
      .req_measured_angle    (req_measured_angle),
      .req_measured_rate     (req_measured_rate),
      .req_filtered_position (req_filtered_position),
      .req_target_angle      (req_target_angle),
      .req_target_rate       (req_target_rate),
      .req_opcode            (req_opcode),
      .cmd                   (cmd),
      .rsp_drive_command     (rsp_drive_command),
      .rsp_rate_loop_output  (rsp_rate_loop_output),
      .rsp_angle_loop_output (rsp_angle_loop_output),
      .rsp_limit_gated       (rsp_limit_gated)
   );

   // a gated word always carries a zero rate loop output
   a_gate_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_limit_gated |-> rsp_rate_loop_output == '0)
      else $error("gated response with nonzero rate output");

   // rate loop output stays within the +-15 clamp
   a_rate_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_rate_loop_output <= 21'sd983040 &&
                     rsp_rate_loop_output >= -21'sd983040))
      else $error("rate loop output beyond clamp");

   // one word in flight: no acceptance in the cycle after an acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // a response is only raised from the final step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(cmd.out_rate))
      else $error("response raised without output step");

endmodule
